// ----- sv/lsis_pkg.sv -----
package lsis_pkg;

  localparam int SIDE_MAX = 64;
  localparam int CW = $clog2(SIDE_MAX);
  localparam int NW = CW + 1;
  localparam int AW = 2 * CW;
  localparam int DEPTH = SIDE_MAX * SIDE_MAX;

  localparam int CNT_W = 13;
  localparam int EDGE_W = 15;
  localparam int ROWS = 5;

  localparam logic [NW-1:0] SIDE_MIN = NW'(2);
  localparam logic [NW-1:0] SIDE_TOP = NW'(SIDE_MAX);

  localparam logic [6:0] SIDE_RESET = 7'd50;
  localparam logic [15:0] INFECT_RESET = 16'd2621;
  localparam logic [15:0] RECOVER_RESET = 16'd6554;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_SEED   = 2'd1,
    KIND_EVENT  = 2'd2,
    KIND_SAMPLE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_REJECT  = 2'd1,
    STAT_OUTSIDE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_SIDE    = 2'd0,
    REG_INFECT  = 2'd1,
    REG_RECOVER = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GATHER,
    ST_DECIDE,
    ST_ACCUM,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       clr;
    logic       add;
    logic       cur;
    logic [2:0] count;
    logic [2:0] row;
  } stat_ctl_t;

endpackage

// ----- sv/lsis_cell_ram.sv -----
module lsis_cell_ram (
  input  logic                    clk,
  input  logic                    we,
  input  logic [lsis_pkg::AW-1:0] waddr,
  input  logic                    wdata,
  input  logic [lsis_pkg::AW-1:0] raddr,
  output logic                    rdata
);

  logic mem [lsis_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/lsis_stats.sv -----
module lsis_stats (
  input  logic                        clk,
  input  lsis_pkg::stat_ctl_t         ctl,
  output logic [lsis_pkg::CNT_W-1:0]  infected_with,
  output logic [lsis_pkg::CNT_W-1:0]  susceptible_with,
  output logic [lsis_pkg::CNT_W-1:0]  total,
  output logic [lsis_pkg::EDGE_W-1:0] si,
  output logic [lsis_pkg::EDGE_W-1:0] ii
);

  logic [lsis_pkg::CNT_W-1:0] ic [lsis_pkg::ROWS];
  logic [lsis_pkg::CNT_W-1:0] sc [lsis_pkg::ROWS];

  for (genvar i = 0; i < lsis_pkg::ROWS; i++) begin : g_row
    always_ff @(posedge clk) begin
      if (ctl.clr) begin
        ic[i] <= '0;
        sc[i] <= '0;
      end else if (ctl.add && ctl.count == 3'(i)) begin
        if (ctl.cur) begin
          ic[i] <= ic[i] + 1'b1;
        end else begin
          sc[i] <= sc[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      total <= '0;
      si <= '0;
      ii <= '0;
    end else if (ctl.add) begin
      if (ctl.cur) begin
        total <= total + 1'b1;
        ii <= ii + lsis_pkg::EDGE_W'(ctl.count);
      end else begin
        si <= si + lsis_pkg::EDGE_W'(ctl.count);
      end
    end
  end

  always_comb begin
    infected_with = '0;
    susceptible_with = '0;
    for (int i = 0; i < lsis_pkg::ROWS; i++) begin
      if (ctl.row == 3'(i)) begin
        infected_with = ic[i];
        susceptible_with = sc[i];
      end
    end
  end

endmodule

// ----- sv/lattice_sis_epidemic_update.sv -----
// Channel   Direction  Handshake            Payload
// in        into       in_valid / in_stall  kind, pos_x, pos_y, draw
// out       out of     out_valid/out_stall  status, cell_infected, neighbour_count, counts, last
// config    into       APB psel/penable     side_length, infect_rate_q16, recover_rate_q16
//
// Seed or event: five reads through the cell memory read port, then a decide step.
// Out-of-range seed or event: no reads, straight to the decide step. Clear: one cell written per cycle.
// Sample: five memory reads and an accumulate for each cell in use, then five results.
// After reset the whole memory is swept before the first item is taken.
// Results sit in an output register; the block stalls in its result step while it is full and out_stall is high.
module lattice_sis_epidemic_update (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  kind,
  input  logic [5:0]                  pos_x,
  input  logic [5:0]                  pos_y,
  input  logic [15:0]                 draw,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic                        cell_infected,
  output logic [2:0]                  neighbour_count,
  output logic [12:0]                 infected_with_count,
  output logic [12:0]                 susceptible_with_count,
  output logic [12:0]                 infected_total,
  output logic [14:0]                 si_edges,
  output logic [14:0]                 ii_edges,
  output logic                        last
);

  localparam int CW = lsis_pkg::CW;
  localparam int NW = lsis_pkg::NW;
  localparam int AW = lsis_pkg::AW;

  logic [6:0]  side_length;
  logic [15:0] infect_rate_q16;
  logic [15:0] recover_rate_q16;

  lsis_pkg::state_t state, state_next;
  lsis_pkg::kind_t  op;
  logic [15:0]      op_draw;
  logic [CW-1:0]    wx;
  logic [CW-1:0]    wy;
  logic             oor;
  logic             reply;
  logic [2:0]       tap;
  logic             cur;
  logic [2:0]       nbr;
  logic [2:0]       row;
  logic [AW-1:0]    sweep;

  logic [NW-1:0] side_n;
  logic [CW-1:0] nm1;
  logic [CW-1:0] xw, xe, ys, yn;
  logic [AW-1:0] raddr;
  logic          rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic          accept;
  logic          out_free;
  logic          load_out;
  logic          last_cell;
  logic          cfg_wr;
  logic          in_oor;
  logic [18:0]   infect_lim;
  logic          cur_new;
  lsis_pkg::status_t stat_new;
  lsis_pkg::stat_ctl_t stat_ctl;

  logic [lsis_pkg::CNT_W-1:0]  st_iw, st_sw, st_total;
  logic [lsis_pkg::EDGE_W-1:0] st_si, st_ii;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_length <= lsis_pkg::SIDE_RESET;
      infect_rate_q16 <= lsis_pkg::INFECT_RESET;
      recover_rate_q16 <= lsis_pkg::RECOVER_RESET;
    end else if (cfg_wr) begin
      case (lsis_pkg::reg_idx_t'(paddr[3:2]))
        lsis_pkg::REG_SIDE:    side_length <= pwdata[6:0];
        lsis_pkg::REG_INFECT:  infect_rate_q16 <= pwdata[15:0];
        lsis_pkg::REG_RECOVER: recover_rate_q16 <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (lsis_pkg::reg_idx_t'(paddr[3:2]))
      lsis_pkg::REG_SIDE:    prdata = {25'd0, side_length};
      lsis_pkg::REG_INFECT:  prdata = {16'd0, infect_rate_q16};
      lsis_pkg::REG_RECOVER: prdata = {16'd0, recover_rate_q16};
      default:               prdata = '0;
    endcase
  end

  always_comb begin
    if (NW'(side_length) < lsis_pkg::SIDE_MIN) begin
      side_n = lsis_pkg::SIDE_MIN;
    end else if (NW'(side_length) > lsis_pkg::SIDE_TOP) begin
      side_n = lsis_pkg::SIDE_TOP;
    end else begin
      side_n = NW'(side_length);
    end
  end

  assign nm1 = CW'(side_n - 1'b1);
  assign xw = (wx == '0) ? nm1 : wx - 1'b1;
  assign xe = (wx == nm1) ? '0 : wx + 1'b1;
  assign ys = (wy == '0) ? nm1 : wy - 1'b1;
  assign yn = (wy == nm1) ? '0 : wy + 1'b1;

  always_comb begin
    case (tap)
      3'd1:    raddr = {wy, xw};
      3'd2:    raddr = {wy, xe};
      3'd3:    raddr = {ys, wx};
      3'd4:    raddr = {yn, wx};
      default: raddr = {wy, wx};
    endcase
  end

  assign in_oor = ({1'b0, pos_x} >= side_n) || ({1'b0, pos_y} >= side_n);
  assign last_cell = (wx == nm1) && (wy == nm1);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != lsis_pkg::ST_IDLE);
  assign accept = in_valid && !in_stall;

  assign infect_lim = 19'(nbr) * 19'(infect_rate_q16);

  always_comb begin
    stat_new = lsis_pkg::STAT_DONE;
    cur_new = 1'b0;
    if (oor) begin
      stat_new = lsis_pkg::STAT_OUTSIDE;
    end else begin
      case (op)
        lsis_pkg::KIND_SEED: begin
          cur_new = 1'b1;
          if (cur) begin
            stat_new = lsis_pkg::STAT_REJECT;
          end
        end
        lsis_pkg::KIND_EVENT: begin
          if (cur) begin
            cur_new = !(op_draw < recover_rate_q16);
          end else begin
            cur_new = (19'(op_draw) < infect_lim);
          end
        end
        default: cur_new = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsis_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_out = 1'b0;
    we = 1'b0;
    waddr = {wy, wx};
    stat_ctl = '{clr: 1'b0, add: 1'b0, cur: cur, count: nbr, row: row};
    case (state)
      lsis_pkg::ST_CLEAR: begin
        we = 1'b1;
        waddr = sweep;
        if (sweep == '1) begin
          state_next = reply ? lsis_pkg::ST_DECIDE : lsis_pkg::ST_IDLE;
        end
      end
      lsis_pkg::ST_IDLE: begin
        if (accept) begin
          case (lsis_pkg::kind_t'(kind))
            lsis_pkg::KIND_CLEAR: state_next = lsis_pkg::ST_CLEAR;
            lsis_pkg::KIND_SAMPLE: begin
              stat_ctl.clr = 1'b1;
              state_next = lsis_pkg::ST_GATHER;
            end
            default: state_next = in_oor ? lsis_pkg::ST_DECIDE : lsis_pkg::ST_GATHER;
          endcase
        end
      end
      lsis_pkg::ST_GATHER: begin
        if (tap == 3'd5) begin
          state_next = (op == lsis_pkg::KIND_SAMPLE) ? lsis_pkg::ST_ACCUM
                                                     : lsis_pkg::ST_DECIDE;
        end
      end
      lsis_pkg::ST_ACCUM: begin
        stat_ctl.add = 1'b1;
        state_next = last_cell ? lsis_pkg::ST_EMIT : lsis_pkg::ST_GATHER;
      end
      lsis_pkg::ST_DECIDE: begin
        if (out_free) begin
          load_out = 1'b1;
          we = !oor && (op == lsis_pkg::KIND_SEED || op == lsis_pkg::KIND_EVENT);
          state_next = lsis_pkg::ST_IDLE;
        end
      end
      lsis_pkg::ST_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (row == 3'd4) begin
            state_next = lsis_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = lsis_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
      reply <= 1'b0;
      tap <= '0;
      row <= '0;
    end else begin
      case (state)
        lsis_pkg::ST_CLEAR: sweep <= sweep + 1'b1;
        lsis_pkg::ST_IDLE: begin
          sweep <= '0;
          reply <= 1'b1;
          tap <= '0;
          row <= '0;
        end
        lsis_pkg::ST_GATHER: tap <= (tap == 3'd5) ? 3'd0 : tap + 1'b1;
        lsis_pkg::ST_EMIT: begin
          if (out_free) begin
            row <= row + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= lsis_pkg::kind_t'(kind);
      op_draw <= draw;
      cur <= 1'b0;
      nbr <= '0;
      if (lsis_pkg::kind_t'(kind) == lsis_pkg::KIND_SAMPLE) begin
        wx <= '0;
        wy <= '0;
        oor <= 1'b0;
      end else begin
        wx <= pos_x;
        wy <= pos_y;
        oor <= (lsis_pkg::kind_t'(kind) != lsis_pkg::KIND_CLEAR) && in_oor;
      end
    end else if (state == lsis_pkg::ST_GATHER) begin
      if (tap == 3'd1) begin
        cur <= rdata;
      end else if (tap != 3'd0) begin
        nbr <= nbr + 3'(rdata);
      end
    end else if (state == lsis_pkg::ST_ACCUM) begin
      nbr <= '0;
      if (wx == nm1) begin
        wx <= '0;
        wy <= wy + 1'b1;
      end else begin
        wx <= wx + 1'b1;
      end
    end
  end

  lsis_cell_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (state != lsis_pkg::ST_CLEAR && cur_new),
    .raddr (raddr),
    .rdata (rdata)
  );

  lsis_stats u_stats (
    .clk              (clk),
    .ctl              (stat_ctl),
    .infected_with    (st_iw),
    .susceptible_with (st_sw),
    .total            (st_total),
    .si               (st_si),
    .ii               (st_ii)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state == lsis_pkg::ST_EMIT) begin
        status <= lsis_pkg::STAT_DONE;
        cell_infected <= 1'b0;
        neighbour_count <= row;
        infected_with_count <= st_iw;
        susceptible_with_count <= st_sw;
        infected_total <= st_total;
        si_edges <= st_si;
        ii_edges <= st_ii;
        last <= (row == 3'd4);
      end else begin
        status <= stat_new;
        cell_infected <= cur_new;
        neighbour_count <= (oor || op == lsis_pkg::KIND_CLEAR) ? 3'd0 : nbr;
        infected_with_count <= '0;
        susceptible_with_count <= '0;
        infected_total <= '0;
        si_edges <= '0;
        ii_edges <= '0;
        last <= 1'b1;
      end
    end
  end

endmodule

// ----- verif/lattice_sis_epidemic_update_tb.sv -----
module lattice_sis_epidemic_update_tb;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  kind;
  logic [5:0]  pos_x;
  logic [5:0]  pos_y;
  logic [15:0] draw;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic        cell_infected;
  logic [2:0]  neighbour_count;
  logic [12:0] infected_with_count;
  logic [12:0] susceptible_with_count;
  logic [12:0] infected_total;
  logic [14:0] si_edges;
  logic [14:0] ii_edges;
  logic        last;

  typedef struct {
    lsis_pkg::status_t status;
    logic        cell_inf;
    logic [2:0]  nbr;
    logic [12:0] inf_with;
    logic [12:0] sus_with;
    logic [12:0] inf_total;
    logic [14:0] si;
    logic [14:0] ii;
    logic        last;
  } lattice_report_t;

  lattice_report_t awaited_reports[$];
  bit              grid [lsis_pkg::SIDE_MAX][lsis_pkg::SIDE_MAX];
  logic [6:0]      side_reg;
  logic [15:0]     infect_reg;
  logic [15:0]     recover_reg;
  int              mismatch_count = 0;
  bit              idle_on = 1'b1;

  lattice_sis_epidemic_update u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int side_in_use();
    if (side_reg < 2) return 2;
    if (side_reg > lsis_pkg::SIDE_MAX) return lsis_pkg::SIDE_MAX;
    return side_reg;
  endfunction

  function automatic int infected_neighbours(int x, int y, int n);
    return int'(grid[y][(x + n - 1) % n]) + int'(grid[y][(x + 1) % n]) +
           int'(grid[(y + n - 1) % n][x]) + int'(grid[(y + 1) % n][x]);
  endfunction

  function automatic void evolve_lattice(lsis_pkg::kind_t k, logic [5:0] x, logic [5:0] y,
                                         logic [15:0] d);
    lattice_report_t r;
    int n, c, cx, cy, kk, tot, si, ii;
    int ic[5];
    int sc[5];
    logic cur;
    n = side_in_use();
    r = '{lsis_pkg::STAT_DONE, 1'b0, 3'd0, 13'd0, 13'd0, 13'd0, 15'd0, 15'd0, 1'b1};
    case (k)
      lsis_pkg::KIND_SAMPLE: begin
        tot = 0;
        si = 0;
        ii = 0;
        for (kk = 0; kk < 5; kk++) begin
          ic[kk] = 0;
          sc[kk] = 0;
        end
        for (cy = 0; cy < n; cy++) begin
          for (cx = 0; cx < n; cx++) begin
            c = infected_neighbours(cx, cy, n);
            if (grid[cy][cx]) begin
              tot++;
              ic[c]++;
              ii += c;
            end else begin
              sc[c]++;
              si += c;
            end
          end
        end
        for (kk = 0; kk < 5; kk++) begin
          r.nbr = 3'(kk);
          r.inf_with = 13'(ic[kk]);
          r.sus_with = 13'(sc[kk]);
          r.inf_total = 13'(tot);
          r.si = 15'(si);
          r.ii = 15'(ii);
          r.last = (kk == 4);
          awaited_reports.push_back(r);
        end
      end
      lsis_pkg::KIND_CLEAR: begin
        grid = '{default: '{default: 1'b0}};
        awaited_reports.push_back(r);
      end
      default: begin
        if (x >= n || y >= n) begin
          r.status = lsis_pkg::STAT_OUTSIDE;
        end else begin
          c = infected_neighbours(x, y, n);
          cur = grid[y][x];
          if (k == lsis_pkg::KIND_SEED) begin
            if (cur) r.status = lsis_pkg::STAT_REJECT;
            else cur = 1'b1;
          end else if (!cur) begin
            if (d < c * infect_reg) cur = 1'b1;
          end else if (d < recover_reg) begin
            cur = 1'b0;
          end
          grid[y][x] = cur;
          r.cell_inf = cur;
          r.nbr = 3'(c);
        end
        awaited_reports.push_back(r);
      end
    endcase
  endfunction

  task automatic send_item(lsis_pkg::kind_t k, int x, int y, int d);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    pos_x <= 6'(x);
    pos_y <= 6'(y);
    draw <= 16'(d);
    do @(posedge clk); while (in_stall !== 1'b0);
    evolve_lattice(k, 6'(x), 6'(y), 16'(d));
  endtask

  task automatic settle_lattice();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_reports.size() != 0);
  endtask

  task automatic write_reg(lsis_pkg::reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      lsis_pkg::REG_SIDE:    side_reg = value[6:0];
      lsis_pkg::REG_INFECT:  infect_reg = value[15:0];
      lsis_pkg::REG_RECOVER: recover_reg = value[15:0];
      default: ;
    endcase
  endtask

  task automatic configure_lattice(int side, int infect, int recover);
    write_reg(lsis_pkg::REG_SIDE, 32'(side));
    write_reg(lsis_pkg::REG_INFECT, 32'(infect));
    write_reg(lsis_pkg::REG_RECOVER, 32'(recover));
  endtask

  task automatic check_field(string label, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  initial begin : report_monitor
    int hold;
    lattice_report_t want;
    forever begin
      hold = idle_on ? $urandom_range(0, 15) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (rst === 1'b1 || out_valid !== 1'b1);
      if (awaited_reports.size() == 0) begin
        $display("%0t unexpected transfer expected none actual status %0d last %0d",
                 $time, status, last);
        mismatch_count++;
      end else begin
        want = awaited_reports.pop_front();
        check_field("status", want.status, status);
        check_field("cell_infected", want.cell_inf, cell_infected);
        check_field("neighbour_count", want.nbr, neighbour_count);
        check_field("infected_with_count", want.inf_with, infected_with_count);
        check_field("susceptible_with_count", want.sus_with, susceptible_with_count);
        check_field("infected_total", want.inf_total, infected_total);
        check_field("si_edges", want.si, si_edges);
        check_field("ii_edges", want.ii, ii_edges);
        check_field("last", want.last, last);
      end
    end
  end

  task automatic test_defaults_after_reset();
    send_item(lsis_pkg::KIND_SEED, 0, 0, 0);
    send_item(lsis_pkg::KIND_SEED, 0, 0, 0);
    send_item(lsis_pkg::KIND_SEED, 49, 49, 0);
    send_item(lsis_pkg::KIND_EVENT, 49, 0, 0);
    send_item(lsis_pkg::KIND_EVENT, 49, 0, 65535);
    send_item(lsis_pkg::KIND_EVENT, 0, 0, 6553);
    send_item(lsis_pkg::KIND_EVENT, 0, 0, 2621);
    send_item(lsis_pkg::KIND_EVENT, 50, 3, 0);
    send_item(lsis_pkg::KIND_EVENT, 3, 63, 0);
    send_item(lsis_pkg::KIND_SEED, 63, 63, 0);
    send_item(lsis_pkg::KIND_SAMPLE, 0, 0, 0);
    settle_lattice();
  endtask

  task automatic test_side_two_wrap();
    configure_lattice(2, 65535, 0);
    send_item(lsis_pkg::KIND_CLEAR, 63, 63, 65535);
    send_item(lsis_pkg::KIND_SEED, 1, 1, 0);
    send_item(lsis_pkg::KIND_EVENT, 0, 1, 65535);
    send_item(lsis_pkg::KIND_EVENT, 0, 1, 0);
    send_item(lsis_pkg::KIND_EVENT, 0, 0, 0);
    send_item(lsis_pkg::KIND_SEED, 2, 0, 0);
    send_item(lsis_pkg::KIND_SAMPLE, 63, 63, 65535);
    settle_lattice();
  endtask

  task automatic test_config_extremes();
    configure_lattice(0, 0, 65535);
    send_item(lsis_pkg::KIND_EVENT, 1, 0, 65534);
    send_item(lsis_pkg::KIND_EVENT, 1, 1, 65534);
    send_item(lsis_pkg::KIND_EVENT, 0, 0, 65535);
    settle_lattice();
    configure_lattice(127, 16384, 1);
    send_item(lsis_pkg::KIND_SEED, 63, 0, 0);
    send_item(lsis_pkg::KIND_EVENT, 0, 63, 0);
    send_item(lsis_pkg::KIND_SAMPLE, 0, 0, 0);
    send_item(lsis_pkg::KIND_CLEAR, 0, 0, 0);
    settle_lattice();
  endtask

  task automatic test_random_epidemic();
    int phase, i, n, side, pick, seeds;
    for (phase = 0; phase < 8; phase++) begin
      idle_on = (phase % 3) != 1;
      pick = $urandom_range(0, 7);
      if (phase == 3) side = $urandom_range(11, 127);
      else if (pick == 0) side = $urandom_range(0, 1);
      else side = $urandom_range(2, 10);
      configure_lattice(side, $urandom_range(0, 65535), $urandom_range(0, 65535));
      n = side_in_use();
      if ($urandom_range(0, 3) == 0)
        send_item(lsis_pkg::KIND_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 65535));
      seeds = $urandom_range(1, 3);
      for (i = 0; i < seeds; i++)
        send_item(lsis_pkg::KIND_SEED, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                  $urandom_range(0, 65535));
      for (i = 0; i < 13; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(lsis_pkg::kind_t'($urandom_range(0, 2)), $urandom_range(0, 63),
                    $urandom_range(0, 63), $urandom_range(0, 65535));
        else
          send_item(lsis_pkg::KIND_EVENT, $urandom_range(0, n - 1),
                    $urandom_range(0, n - 1), $urandom_range(0, 65535));
      end
      send_item(lsis_pkg::KIND_SAMPLE, $urandom_range(0, 63), $urandom_range(0, 63),
                $urandom_range(0, 65535));
      settle_lattice();
    end
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    kind <= lsis_pkg::KIND_CLEAR;
    pos_x <= '0;
    pos_y <= '0;
    draw <= '0;
    grid = '{default: '{default: 1'b0}};
    side_reg = lsis_pkg::SIDE_RESET;
    infect_reg = lsis_pkg::INFECT_RESET;
    recover_reg = lsis_pkg::RECOVER_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_defaults_after_reset();
    test_side_two_wrap();
    test_config_extremes();
    test_random_epidemic();

    settle_lattice();
    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
